// File: hdl/tmf_pkg.sv
// Shared constants and types for the timestamp matcher and frame transform.
`default_nettype none
package tmf_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam logic [1:0] CMD_CAMERA   = 2'd0;
  localparam logic [1:0] CMD_ODOMETRY = 2'd1;
  localparam logic [1:0] CMD_WORLD    = 2'd2;

  localparam logic [1:0] ST_STORED      = 2'd0;
  localparam logic [1:0] ST_NO_CAMERA   = 2'd1;
  localparam logic [1:0] ST_NO_ODOMETRY = 2'd2;
  localparam logic [1:0] ST_MATCHED     = 2'd3;

  localparam logic [1:0] CFG_CAMERA_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_ODOMETRY_WINDOW = 2'd1;
  localparam logic [1:0] CFG_MIN_SAMPLES     = 2'd2;

  typedef logic [RING_AW-1:0] slot_t;

  typedef struct packed {
    logic  cam_we;
    logic  odo_we;
    slot_t cam_waddr;
    slot_t odo_waddr;
    slot_t cam_raddr;
    slot_t odo_raddr;
  } ring_ctl_t;

  typedef struct packed {
    logic             start;
    logic [3:0][31:0] quat;
    logic [2:0][32:0] diff;
  } math_req_t;

endpackage
`default_nettype wire

// File: hdl/tmf_rings.sv
// Camera and odometry ring memories with registered read ports.
`default_nettype none
module tmf_rings (
  input  logic              clk,
  input  tmf_pkg::ring_ctl_t ctl,
  input  logic [63:0]       wr_stamp,
  input  logic [223:0]      wr_pose,
  output logic [63:0]       cam_time_q,
  output logic [95:0]       cam_point_q,
  output logic [63:0]       odo_time_q,
  output logic [223:0]      odo_pose_q
);
  import tmf_pkg::*;

  logic [63:0]  cam_time_mem [RING_DEPTH];
  logic [95:0]  cam_point_mem [RING_DEPTH];
  logic [63:0]  odo_time_mem [RING_DEPTH];
  logic [223:0] odo_pose_mem [RING_DEPTH];

  // write the camera ring, read it through a registered port
  always_ff @(posedge clk) begin
    if (ctl.cam_we) begin
      cam_time_mem[ctl.cam_waddr]  <= wr_stamp;
      cam_point_mem[ctl.cam_waddr] <= wr_pose[95:0];
    end
    cam_time_q  <= cam_time_mem[ctl.cam_raddr];
    cam_point_q <= cam_point_mem[ctl.cam_raddr];
  end

  // write the odometry ring, read it through a registered port
  always_ff @(posedge clk) begin
    if (ctl.odo_we) begin
      odo_time_mem[ctl.odo_waddr] <= wr_stamp;
      odo_pose_mem[ctl.odo_waddr] <= wr_pose;
    end
    odo_time_q <= odo_time_mem[ctl.odo_raddr];
    odo_pose_q <= odo_pose_mem[ctl.odo_raddr];
  end

endmodule
`default_nettype wire

// File: hdl/tmf_math.sv
// Quaternion normalisation, rotation build and world-to-body transform sequencer.
`default_nettype none
module tmf_math (
  input  logic               clk,
  input  logic               rst_n,
  input  tmf_pkg::math_req_t req,
  output logic               done,
  output logic [2:0][31:0]   body
);
  import tmf_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_SQ   = 3'd1;
  localparam logic [2:0] M_SQRT = 3'd2;
  localparam logic [2:0] M_DIV  = 3'd3;
  localparam logic [2:0] M_PROD = 3'd4;
  localparam logic [2:0] M_ROT  = 3'd5;
  localparam logic [2:0] M_BODY = 3'd6;

  localparam logic [1:0] K_DIAG = 2'd0;
  localparam logic [1:0] K_ADD  = 2'd1;
  localparam logic [1:0] K_SUB  = 2'd2;

  localparam logic signed [65:0] ONE_Q60  = 66'sd1152921504606846976;
  localparam logic signed [67:0] HALF_Q30 = 68'sd536870912;
  localparam logic signed [37:0] UNIT_Q30 = 38'sd1073741824;
  localparam logic [32:0]        UNIT_MAG = 33'd1073741824;
  localparam logic signed [37:0] INT_MAX  = 38'sd2147483647;
  localparam logic signed [37:0] INT_MIN  = -38'sd2147483648;

  // quaternion product pairs: {a, b} with x=0, y=1, z=2, w=3
  function automatic logic [3:0] prod_pair(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0: r = {2'd0, 2'd0};
      4'd1: r = {2'd1, 2'd1};
      4'd2: r = {2'd2, 2'd2};
      4'd3: r = {2'd0, 2'd1};
      4'd4: r = {2'd0, 2'd2};
      4'd5: r = {2'd1, 2'd2};
      4'd6: r = {2'd3, 2'd0};
      4'd7: r = {2'd3, 2'd1};
      4'd8: r = {2'd3, 2'd2};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // rotation entry recipe: {kind, first product, second product}
  function automatic logic [9:0] rot_map(input logic [3:0] e);
    logic [9:0] r;
    case (e)
      4'd0: r = {K_DIAG, 4'd1, 4'd2};
      4'd1: r = {K_SUB,  4'd3, 4'd8};
      4'd2: r = {K_ADD,  4'd4, 4'd7};
      4'd3: r = {K_ADD,  4'd3, 4'd8};
      4'd4: r = {K_DIAG, 4'd0, 4'd2};
      4'd5: r = {K_SUB,  4'd5, 4'd6};
      4'd6: r = {K_SUB,  4'd4, 4'd7};
      4'd7: r = {K_ADD,  4'd5, 4'd6};
      4'd8: r = {K_DIAG, 4'd0, 4'd1};
      default: r = {K_DIAG, 4'd0, 4'd0};
    endcase
    return r;
  endfunction

  // transform step: {output row i, term j, rotation index of R[j][i]}
  function automatic logic [7:0] body_map(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd0: r = {2'd0, 2'd0, 4'd0};
      4'd1: r = {2'd0, 2'd1, 4'd3};
      4'd2: r = {2'd0, 2'd2, 4'd6};
      4'd3: r = {2'd1, 2'd0, 4'd1};
      4'd4: r = {2'd1, 2'd1, 4'd4};
      4'd5: r = {2'd1, 2'd2, 4'd7};
      4'd6: r = {2'd2, 2'd0, 4'd2};
      4'd7: r = {2'd2, 2'd1, 4'd5};
      4'd8: r = {2'd2, 2'd2, 4'd8};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  logic [2:0]        st_r;
  logic [5:0]        k_r;
  logic [1:0]        c_r;
  logic              pv_r;
  logic [3:0]        kq_r;
  logic signed [65:0] prod_r;
  logic [64:0]       sum_r;
  logic [63:0]       v_r;
  logic [35:0]       rem_r;
  logic [31:0]       root_r;
  logic signed [31:0] quat_r [4];
  logic signed [32:0] diff_r [3];
  logic signed [31:0] u_r [4];
  logic signed [63:0] p_r [9];
  logic signed [31:0] rot_r [9];
  logic signed [67:0] acc_r;
  logic [2:0][31:0]  body_r;
  logic              done_r;
  logic              neg_r;
  logic              ovf_r;
  logic [32:0]       ml_r;
  logic [32:0]       quo_r;

  logic signed [32:0] mul_a, mul_b;
  logic [3:0]        pair;
  logic [7:0]        bmap, bq;
  logic [9:0]        rmap;
  logic [3:0]        nsteps;
  logic              phase_end;
  logic [64:0]       sum_nxt;
  logic [35:0]       sq_sh, sq_trial;
  logic              sq_take;
  logic [31:0]       root_nxt;
  logic [32:0]       den;
  logic [63:0]       num, mag;
  logic [35:0]       dv_sh;
  logic              dv_take;
  logic [32:0]       umag;
  logic signed [31:0] uval;
  logic signed [65:0] ta, tb, mval;
  logic signed [67:0] mrnd;
  logic signed [37:0] mshr;
  logic signed [31:0] rval;
  logic signed [67:0] acc_nxt, brnd;
  logic signed [37:0] bshr;
  logic signed [31:0] bval;

  assign pair = prod_pair(k_r[3:0]);
  assign bmap = body_map(k_r[3:0]);
  assign bq   = body_map(kq_r);
  assign rmap = rot_map(k_r[3:0]);

  // select the shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      M_SQ: begin
        mul_a = {quat_r[k_r[1:0]][31], quat_r[k_r[1:0]]};
        mul_b = mul_a;
      end
      M_PROD: begin
        mul_a = {u_r[pair[3:2]][31], u_r[pair[3:2]]};
        mul_b = {u_r[pair[1:0]][31], u_r[pair[1:0]]};
      end
      M_BODY: begin
        mul_a = {rot_r[bmap[3:0]][31], rot_r[bmap[3:0]]};
        mul_b = diff_r[bmap[5:4]];
      end
      default: ;
    endcase
  end

  always_comb begin
    case (st_r)
      M_SQ:    nsteps = 4'd4;
      default: nsteps = 4'd9;
    endcase
  end
  assign phase_end = (k_r == {2'b00, nsteps}) && pv_r;

  // square sum and square root step
  assign sum_nxt  = sum_r + prod_r[64:0];
  assign sq_sh    = {rem_r[33:0], v_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_take  = sq_sh >= sq_trial;
  assign root_nxt = {root_r[30:0], sq_take};

  // normalising division step
  assign den     = {root_r, 1'b0};
  assign num     = {{2{quat_r[c_r][31]}}, quat_r[c_r], 30'd0} + {32'd0, root_r};
  assign mag     = num[63] ? (~num + {31'd0, den}) : num;
  assign dv_sh   = {rem_r[34:0], ml_r[32]};
  assign dv_take = dv_sh >= {3'b000, den};
  assign umag    = (ovf_r || (quo_r > UNIT_MAG)) ? UNIT_MAG : quo_r;
  assign uval    = neg_r ? -$signed(umag[31:0]) : $signed(umag[31:0]);

  // rotation entry from stored products, rounded and clamped
  always_comb begin
    ta = {{2{p_r[rmap[7:4]][63]}}, p_r[rmap[7:4]]};
    tb = {{2{p_r[rmap[3:0]][63]}}, p_r[rmap[3:0]]};
    case (rmap[9:8])
      K_DIAG:  mval = ONE_Q60 - ((ta + tb) <<< 1);
      K_ADD:   mval = (ta + tb) <<< 1;
      K_SUB:   mval = (ta - tb) <<< 1;
      default: mval = '0;
    endcase
    mrnd = {{2{mval[65]}}, mval} + HALF_Q30;
    mshr = mrnd[67:30];
    if (mshr > UNIT_Q30)       rval = UNIT_Q30[31:0];
    else if (mshr < -UNIT_Q30) rval = -UNIT_Q30[31:0];
    else                       rval = mshr[31:0];
  end

  // body accumulation, rounded and saturated
  always_comb begin
    acc_nxt = acc_r + {{2{prod_r[65]}}, prod_r};
    brnd    = acc_nxt + HALF_Q30;
    bshr    = brnd[67:30];
    if (bshr > INT_MAX)      bval = INT_MAX[31:0];
    else if (bshr < INT_MIN) bval = INT_MIN[31:0];
    else                     bval = bshr[31:0];
  end

  // register every product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequence the phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
      c_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        M_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 4; i++) quat_r[i] <= $signed(req.quat[i]);
            for (int i = 0; i < 3; i++) diff_r[i] <= $signed(req.diff[i]);
            sum_r <= '0;
            k_r   <= '0;
            pv_r  <= 1'b0;
            st_r  <= M_SQ;
          end
        end
        M_SQ, M_PROD, M_BODY: begin
          if (k_r < {2'b00, nsteps}) begin
            pv_r <= 1'b1;
            kq_r <= k_r[3:0];
            k_r  <= k_r + 6'd1;
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r) begin
            case (st_r)
              M_SQ:   sum_r <= sum_nxt;
              M_PROD: p_r[kq_r] <= prod_r[63:0];
              default: begin
                if (bq[5:4] == 2'd2) begin
                  body_r[bq[7:6]] <= bval;
                  acc_r <= '0;
                end else begin
                  acc_r <= acc_nxt;
                end
              end
            endcase
          end
          if (phase_end) begin
            k_r  <= '0;
            pv_r <= 1'b0;
            case (st_r)
              M_SQ: begin
                v_r    <= {1'b0, sum_nxt[64:2]};
                rem_r  <= '0;
                root_r <= '0;
                st_r   <= M_SQRT;
              end
              M_PROD: st_r <= M_ROT;
              default: begin
                done_r <= 1'b1;
                st_r   <= M_IDLE;
              end
            endcase
          end
        end
        M_SQRT: begin
          rem_r  <= sq_take ? (sq_sh - sq_trial) : sq_sh;
          root_r <= root_nxt;
          v_r    <= {v_r[61:0], 2'b00};
          k_r    <= k_r + 6'd1;
          if (k_r == 6'd31) begin
            k_r <= '0;
            c_r <= '0;
            if (root_nxt == '0) begin
              // degenerate quaternion: identity rotation
              for (int i = 0; i < 9; i++) rot_r[i] <= '0;
              rot_r[0] <= UNIT_Q30[31:0];
              rot_r[4] <= UNIT_Q30[31:0];
              rot_r[8] <= UNIT_Q30[31:0];
              acc_r    <= '0;
              st_r     <= M_BODY;
            end else begin
              st_r <= M_DIV;
            end
          end
        end
        M_DIV: begin
          if (k_r == 6'd0) begin
            rem_r <= {5'd0, mag[63:33]};
            ml_r  <= mag[32:0];
            neg_r <= num[63];
            ovf_r <= {2'b00, mag[63:33]} >= den;
            quo_r <= '0;
            k_r   <= 6'd1;
          end else if (k_r <= 6'd33) begin
            rem_r <= dv_take ? (dv_sh - {3'b000, den}) : dv_sh;
            quo_r <= {quo_r[31:0], dv_take};
            ml_r  <= {ml_r[31:0], 1'b0};
            k_r   <= k_r + 6'd1;
          end else begin
            u_r[c_r] <= uval;
            k_r      <= '0;
            if (c_r == 2'd3) st_r <= M_PROD;
            else             c_r  <= c_r + 2'd1;
          end
        end
        M_ROT: begin
          rot_r[k_r[3:0]] <= rval;
          k_r <= k_r + 6'd1;
          if (k_r == 6'd8) begin
            k_r   <= '0;
            acc_r <= '0;
            st_r  <= M_BODY;
          end
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign body = body_r;

endmodule
`default_nettype wire

// File: hdl/timestamp_matcher_frame_transform.sv
// Top level: command decode, ring scans, match decision and result words.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+---------------------------------
//   input   | start, busy, in_*              | taken when start & !busy
//   result  | out_strobe, out_*              | one cycle per word, no stall
//   config  | cfg_valid, cfg_ready, cfg_*    | written when valid & ready
//
// Camera and odometry words are stored when taken; their result word is strobed in the cycle after.
// A world point scans the camera ring and, on a camera match, the odometry ring, one entry
// per memory read, then runs the math sequencer, whose time is set mostly by the square
// root, one bit per cycle, and the four normalising divisions.
// Reset is synchronous; ring contents are not cleared, the fill counts are.
// The receiver cannot stall results; busy holds off new words while a point is in work.
`default_nettype none
module timestamp_matcher_frame_transform (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_stamp_ns,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_quat_x,
  input  logic [31:0] in_quat_y,
  input  logic [31:0] in_quat_z,
  input  logic [31:0] in_quat_w,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_cam_x,
  output logic [31:0] out_cam_y,
  output logic [31:0] out_cam_z,
  output logic [31:0] out_body_x,
  output logic [31:0] out_body_y,
  output logic [31:0] out_body_z,
  output logic [15:0] out_matched_total,
  output logic        out_solve_due,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tmf_pkg::*;

  localparam int SUM_W = FILL_W + 1;

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SCAN_C = 2'd1;
  localparam logic [1:0] T_SCAN_O = 2'd2;
  localparam logic [1:0] T_MATH   = 2'd3;

  // oldest slot of a ring from its next slot and fill
  function automatic slot_t oldest(input slot_t nxt, input logic [FILL_W-1:0] fill);
    logic [SUM_W-1:0] s;
    s = {{(SUM_W - RING_AW){1'b0}}, nxt} + SUM_W'(RING_DEPTH) - {1'b0, fill};
    if (s >= SUM_W'(RING_DEPTH)) s = s - SUM_W'(RING_DEPTH);
    return s[RING_AW-1:0];
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [1:0]        st_r;
  logic [31:0]       cam_win_r, odo_win_r;
  logic [15:0]       min_cnt_r, samples_r;
  logic [FILL_W-1:0] cam_fill_r, odo_fill_r, scan_cnt_r;
  slot_t             cam_next_r, odo_next_r, idx_r;
  logic              pend_r, found_r;
  logic [63:0]       best_r, stamp_r;
  logic [2:0][31:0]  pw_r;
  logic [95:0]       cam_pt_r;
  logic [223:0]      pose_r;

  logic              out_valid_r, due_r;
  logic [1:0]        status_r;
  logic [2:0][31:0]  cam_out_r, body_out_r;
  logic [15:0]       total_r;

  ring_ctl_t         ctl;
  math_req_t         req;
  logic [63:0]       cam_time_q, odo_time_q;
  logic [95:0]       cam_point_q;
  logic [223:0]      odo_pose_q;
  logic              math_done;
  logic [2:0][31:0]  math_body;

  logic              accept;
  logic [FILL_W-1:0] fill_sel;
  logic [63:0]       time_sel, gap;
  logic              issue, update, scan_done, matched;
  logic [31:0]       win_sel;
  logic [15:0]       samples_nxt;

  assign busy      = (st_r != T_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // scan datapath shared by both rings
  assign fill_sel  = (st_r == T_SCAN_C) ? cam_fill_r : odo_fill_r;
  assign time_sel  = (st_r == T_SCAN_C) ? cam_time_q : odo_time_q;
  assign win_sel   = (st_r == T_SCAN_C) ? cam_win_r : odo_win_r;
  assign gap       = (time_sel >= stamp_r) ? (time_sel - stamp_r) : (stamp_r - time_sel);
  assign issue     = scan_cnt_r < fill_sel;
  assign update    = pend_r && (!found_r || (gap < best_r));
  assign scan_done = !issue && !pend_r;
  assign matched   = found_r && (best_r <= {32'd0, win_sel});

  assign samples_nxt = (samples_r == 16'hFFFF) ? samples_r : samples_r + 16'd1;

  // ring write and read control
  always_comb begin
    ctl.cam_we    = accept && (in_command == CMD_CAMERA);
    ctl.odo_we    = accept && (in_command == CMD_ODOMETRY);
    ctl.cam_waddr = cam_next_r;
    ctl.odo_waddr = odo_next_r;
    ctl.cam_raddr = idx_r;
    ctl.odo_raddr = idx_r;
  end

  // hand the matched pose to the math sequencer
  always_comb begin
    req.start = (st_r == T_SCAN_O) && scan_done && matched;
    req.quat  = pose_r[223:96];
    for (int i = 0; i < 3; i++)
      req.diff[i] = {pw_r[i][31], pw_r[i]} - {pose_r[32*i+31], pose_r[32*i +: 32]};
  end

  tmf_rings u_rings (
    .clk         (clk),
    .ctl         (ctl),
    .wr_stamp    (in_stamp_ns),
    .wr_pose     ({in_quat_w, in_quat_z, in_quat_y, in_quat_x, in_pos_z, in_pos_y, in_pos_x}),
    .cam_time_q  (cam_time_q),
    .cam_point_q (cam_point_q),
    .odo_time_q  (odo_time_q),
    .odo_pose_q  (odo_pose_q)
  );

  tmf_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (math_done),
    .body  (math_body)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_win_r <= 32'd30000000;
      odo_win_r <= 32'd50000000;
      min_cnt_r <= 16'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAMERA_WINDOW:   cam_win_r <= cfg_data;
        CFG_ODOMETRY_WINDOW: odo_win_r <= cfg_data;
        CFG_MIN_SAMPLES:     min_cnt_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // keep the nearest entry and its payload while scanning
  always_ff @(posedge clk) begin
    if (update) begin
      best_r <= gap;
      if (st_r == T_SCAN_C) cam_pt_r <= cam_point_q;
      else                  pose_r   <= odo_pose_q;
    end
  end

  // command sequencer and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      cam_fill_r  <= '0;
      odo_fill_r  <= '0;
      cam_next_r  <= '0;
      odo_next_r  <= '0;
      samples_r   <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (st_r)
        T_IDLE: begin
          if (accept) begin
            status_r   <= ST_STORED;
            cam_out_r  <= '0;
            body_out_r <= '0;
            total_r    <= samples_r;
            due_r      <= 1'b0;
            case (in_command)
              CMD_CAMERA: begin
                cam_next_r  <= slot_inc(cam_next_r);
                if (cam_fill_r < FILL_W'(RING_DEPTH)) cam_fill_r <= cam_fill_r + 1'b1;
                out_valid_r <= 1'b1;
              end
              CMD_ODOMETRY: begin
                odo_next_r  <= slot_inc(odo_next_r);
                if (odo_fill_r < FILL_W'(RING_DEPTH)) odo_fill_r <= odo_fill_r + 1'b1;
                out_valid_r <= 1'b1;
              end
              CMD_WORLD: begin
                stamp_r    <= in_stamp_ns;
                pw_r       <= {in_pos_z, in_pos_y, in_pos_x};
                scan_cnt_r <= '0;
                idx_r      <= oldest(cam_next_r, cam_fill_r);
                pend_r     <= 1'b0;
                found_r    <= 1'b0;
                st_r       <= T_SCAN_C;
              end
              default: ;
            endcase
          end
        end
        T_SCAN_C, T_SCAN_O: begin
          pend_r <= issue;
          if (issue) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
            idx_r      <= slot_inc(idx_r);
          end
          if (update) found_r <= 1'b1;
          if (scan_done) begin
            if (!matched) begin
              status_r    <= (st_r == T_SCAN_C) ? ST_NO_CAMERA : ST_NO_ODOMETRY;
              out_valid_r <= 1'b1;
              st_r        <= T_IDLE;
            end else if (st_r == T_SCAN_C) begin
              scan_cnt_r <= '0;
              idx_r      <= oldest(odo_next_r, odo_fill_r);
              found_r    <= 1'b0;
              st_r       <= T_SCAN_O;
            end else begin
              st_r <= T_MATH;
            end
          end
        end
        T_MATH: begin
          if (math_done) begin
            status_r    <= ST_MATCHED;
            cam_out_r   <= cam_pt_r;
            body_out_r  <= math_body;
            samples_r   <= samples_nxt;
            total_r     <= samples_nxt;
            due_r       <= samples_nxt >= min_cnt_r;
            out_valid_r <= 1'b1;
            st_r        <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_valid_r;
  assign out_status        = status_r;
  assign out_cam_x         = cam_out_r[0];
  assign out_cam_y         = cam_out_r[1];
  assign out_cam_z         = cam_out_r[2];
  assign out_body_x        = body_out_r[0];
  assign out_body_y        = body_out_r[1];
  assign out_body_z        = body_out_r[2];
  assign out_matched_total = total_r;
  assign out_solve_due     = due_r;

endmodule
`default_nettype wire
